### hw/rtl/vsp_pkg.sv
// vsp_pkg: shared types and constants for the variable rate sample player
// no dependencies
package vsp_pkg;

  // operation codes of an input transaction
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_STEP    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_START    = 3'd0;
  localparam logic [2:0] CFG_END      = 3'd1;
  localparam logic [2:0] CFG_FADE_IN  = 3'd2;
  localparam logic [2:0] CFG_FADE_OUT = 3'd3;
  localparam logic [2:0] CFG_RATE     = 3'd4;

  // quotient bits produced by the fade divider
  localparam int unsigned DivSteps = 24;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_A,
    DP_MUL_B,
    DP_MUL_C,
    DP_MUL_D,
    DP_SUM,
    DP_DIV
  } dp_op_e;

  typedef struct packed {
    logic   take;    // input transaction accepted this cycle
    dp_op_e op;      // sequenced datapath operation
    logic   finish;  // load the output register
  } vsp_cmd_t;

endpackage

### hw/rtl/vsp_ctrl.sv
// vsp_ctrl: controller state machine of the sample player
// depends on vsp_pkg
module vsp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       operation_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vsp_pkg::vsp_cmd_t cmd_o
);
  import vsp_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_MUL_A = 4'd2;
  localparam logic [3:0] ST_MUL_B = 4'd3;
  localparam logic [3:0] ST_MUL_C = 4'd4;
  localparam logic [3:0] ST_MUL_D = 4'd5;
  localparam logic [3:0] ST_SUM   = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  localparam int unsigned CntW = $clog2(DivSteps);

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and command decode
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '{take: 1'b0, op: DP_NOP, finish: 1'b0};
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = (operation_i == OP_STEP) ? ST_LOAD : ST_FIN;
        end
      end
      ST_LOAD:  begin cmd_o.op = DP_LOAD;  state_d = ST_MUL_A; end
      ST_MUL_A: begin cmd_o.op = DP_MUL_A; state_d = ST_MUL_B; end
      ST_MUL_B: begin cmd_o.op = DP_MUL_B; state_d = ST_MUL_C; end
      ST_MUL_C: begin cmd_o.op = DP_MUL_C; state_d = ST_MUL_D; end
      ST_MUL_D: begin cmd_o.op = DP_MUL_D; state_d = ST_SUM;   end
      ST_SUM: begin
        cmd_o.op = DP_SUM;
        cnt_d    = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = DP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hw/rtl/vsp_datapath.sv
// vsp_datapath: sample memory, position, fade multiply and divide, output register
// depends on vsp_pkg
module vsp_datapath #(
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vsp_pkg::vsp_cmd_t   cmd_i,
  input  logic [1:0]          operation_i,
  input  logic [15:0]         address_i,
  input  logic signed [23:0]  sample_value_i,
  input  logic signed [5:0]   advance_count_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [23:0]         cfg_wdata_i,
  output logic signed [23:0]  audio_out_o,
  output logic signed [17:0]  position_o,
  output logic                at_end_o
);
  import vsp_pkg::*;

  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);

  // configuration registers
  logic [16:0]        start_q, end_q, fade_in_q, fade_out_q;
  logic signed [23:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      end_q      <= 17'd65536;
      fade_in_q  <= '0;
      fade_out_q <= '0;
      rate_q     <= 24'sd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START:    start_q    <= cfg_wdata_i[16:0];
        CFG_END:      end_q      <= cfg_wdata_i[16:0];
        CFG_FADE_IN:  fade_in_q  <= cfg_wdata_i[16:0];
        CFG_FADE_OUT: fade_out_q <= cfg_wdata_i[16:0];
        CFG_RATE:     rate_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective playable range
  logic [16:0] e_w, s_w;
  logic        rev;
  assign e_w = ({15'd0, end_q} > 32'(SAMPLE_DEPTH)) ? 17'(SAMPLE_DEPTH) : end_q;
  assign s_w = (start_q > e_w) ? e_w : start_q;
  assign rev = rate_q[23];

  logic signed [18:0] s19, e19, p19;
  logic signed [17:0] p_q;
  logic [15:0]        frac_q;
  assign s19 = $signed({2'b00, s_w});
  assign e19 = $signed({2'b00, e_w});
  assign p19 = {p_q[17], p_q};

  // fade gain terms at the current position
  logic               in_range;
  logic signed [18:0] a19, b19;
  logic [16:0]        a_w, b_w, lin_w, lout_w, n1_w, d1_w, n2_w, d2_w;
  always_comb begin
    in_range = (p19 >= s19) && (p19 < e19);
    if (rev) begin
      a19    = e19 - 19'sd1 - p19;
      b19    = p19 - s19 + 19'sd1;
      lin_w  = fade_out_q;
      lout_w = fade_in_q;
    end else begin
      a19    = p19 - s19;
      b19    = e19 - p19;
      lin_w  = fade_in_q;
      lout_w = fade_out_q;
    end
    a_w = a19[16:0];
    b_w = b19[16:0];
    if (lin_w != '0 && a_w < lin_w) begin
      n1_w = a_w;
      d1_w = lin_w;
    end else begin
      n1_w = 17'd1;
      d1_w = 17'd1;
    end
    if (lout_w != '0 && b_w < lout_w) begin
      n2_w = b_w;
      d2_w = lout_w;
    end else begin
      n2_w = 17'd1;
      d2_w = 17'd1;
    end
  end

  // advance with floor on the phase and clamp to the range
  logic signed [29:0] rc;
  logic signed [30:0] t_w;
  logic signed [18:0] pn, lo, hi, pc, rst_pos;
  always_comb begin
    rc  = rate_q * advance_count_i;
    t_w = $signed({15'd0, frac_q}) + 31'(rc);
    pn  = p19 + {{4{t_w[30]}}, t_w[30:16]};
    lo  = rev ? s19 - 19'sd1 : s19;
    hi  = rev ? e19 - 19'sd1 : e19;
    pc  = pn;
    if (pn < lo) pc = lo;
    if (pn > hi) pc = hi;
    rst_pos = rev ? e19 - 19'sd1 : s19;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q    <= '0;
      frac_q <= '0;
    end else if (cmd_i.take) begin
      if (operation_i == OP_RESTART) begin
        p_q    <= rst_pos[17:0];
        frac_q <= '0;
      end else if (operation_i == OP_STEP) begin
        p_q    <= pc[17:0];
        frac_q <= t_w[15:0];
      end
    end
  end

  // sample memory
  logic [23:0]   mem [SAMPLE_DEPTH];
  logic [23:0]   rdata_q;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_ok;
  assign wr_addr = AW'({16'd0, address_i});
  assign rd_addr = AW'({16'd0, p_q[15:0]});
  assign wr_ok   = {16'd0, address_i} < 32'(SAMPLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && operation_i == OP_WRITE && wr_ok) begin
      mem[wr_addr] <= sample_value_i;
    end
    if (cmd_i.take) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // gain terms latched per transaction, then multiply and divide sequence
  logic [16:0] n1_q, n2_q, d1_q, d2_q;
  logic        zero_q, neg_q;
  logic [23:0] mag_q, quot_q, nlow_q;
  logic [40:0] a_q, b_q;
  logic [33:0] c_q, d_q, rem_q;
  logic [23:0] mul_x;
  logic [16:0] mul_y;
  logic [40:0] prod;
  logic [57:0] sum_w;
  logic [34:0] rem2;
  logic        qbit;

  always_comb begin
    case (cmd_i.op)
      DP_MUL_B: begin mul_x = a_q[23:0];             mul_y = n2_q; end
      DP_MUL_C: begin mul_x = {7'd0, a_q[40:24]};    mul_y = n2_q; end
      DP_MUL_D: begin mul_x = {7'd0, d1_q};          mul_y = d2_q; end
      default:  begin mul_x = mag_q;                 mul_y = n1_q; end
    endcase
    prod  = 41'(mul_x) * 41'(mul_y);
    sum_w = 58'(b_q) + {c_q, 24'd0};
    rem2  = {rem_q, nlow_q[23]};
    qbit  = rem2 >= {1'b0, d_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      n1_q   <= n1_w;
      n2_q   <= n2_w;
      d1_q   <= d1_w;
      d2_q   <= d2_w;
      zero_q <= !(operation_i == OP_STEP && in_range);
    end
    case (cmd_i.op)
      DP_LOAD: begin
        neg_q <= rdata_q[23];
        mag_q <= rdata_q[23] ? 24'(-rdata_q) : rdata_q;
      end
      DP_MUL_A: a_q <= prod;
      DP_MUL_B: b_q <= prod;
      DP_MUL_C: c_q <= prod[33:0];
      DP_MUL_D: d_q <= prod[33:0];
      DP_SUM: begin
        rem_q  <= sum_w[57:24];
        nlow_q <= sum_w[23:0];
      end
      DP_DIV: begin
        rem_q  <= qbit ? 34'(rem2 - {1'b0, d_q}) : rem2[33:0];
        nlow_q <= {nlow_q[22:0], 1'b0};
        quot_q <= {quot_q[22:0], qbit};
      end
      default: ;
    endcase
  end

  // output register
  logic signed [23:0] audio_q;
  logic signed [17:0] pos_q;
  logic               at_end_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      audio_q  <= zero_q ? '0 : (neg_q ? 24'(-quot_q) : quot_q);
      pos_q    <= p_q;
      at_end_q <= rev ? (p19 == s19 - 19'sd1) : (p19 == e19);
    end
  end

  assign audio_out_o = audio_q;
  assign position_o  = pos_q;
  assign at_end_o    = at_end_q;

endmodule

### hw/rtl/variable_rate_sample_player_top.sv
// variable_rate_sample_player_top: sample playback voice with fades
// depends on vsp_pkg, vsp_ctrl, vsp_datapath
//
//  channel   direction  handshake                 payload
//  input     in         in_valid_i / in_ready_o   operation, address, sample_value, advance_count
//  output    out        out_valid_o / out_ready_i audio_out, position, at_end
//  config    in         cfg_we_i (no wait)        cfg_index_i, cfg_wdata_i
//
// write, restart and unused codes skip the datapath sequence and go straight to the finish state
// output and advance runs through a memory read, four passes of the shared
// 24x17 multiplier, one add, and 24 steps of the restoring fade divider
// one transaction at a time; a new one is accepted while the last result waits
// a finished result stalls in the controller until the output register frees
// reset clears position, phase, configuration and control state; sample memory is not cleared
module variable_rate_sample_player_top #(
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        address_i,
  input  logic signed [23:0] sample_value_i,
  input  logic signed [5:0]  advance_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] audio_out_o,
  output logic signed [17:0] position_o,
  output logic               at_end_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_wdata_i
);
  import vsp_pkg::*;

  vsp_cmd_t cmd;

  // controller
  vsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath
  vsp_datapath #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .operation_i     (operation_i),
    .address_i       (address_i),
    .sample_value_i  (sample_value_i),
    .advance_count_i (advance_count_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .audio_out_o     (audio_out_o),
    .position_o      (position_o),
    .at_end_o        (at_end_o)
  );

endmodule

### verif/vsp_checker.sv
// vsp_checker: watches the config port and both channels of the sample player,
// predicts every result and compares it field by field; depends on vsp_pkg
module vsp_checker #(
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        address_i,
  input  logic signed [23:0] sample_value_i,
  input  logic signed [5:0]  advance_count_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [23:0] audio_out_i,
  input  logic signed [17:0] position_i,
  input  logic               at_end_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_wdata_i,
  output int                 err_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import vsp_pkg::*;

  typedef struct {
    logic signed [23:0] audio;
    logic signed [17:0] pos;
    logic               at_end;
  } voice_result_t;

  voice_result_t      voice_results_q[$];
  logic signed [23:0] sample_mem[int];
  longint             play_pos, phase_frac;
  longint             start_reg, end_reg, fade_in_reg, fade_out_reg, rate_reg;
  int                 mismatches = 0;
  int                 pending = 0;

  assign err_count_o = mismatches + pending;

  function automatic longint eff_end();
    return (end_reg > SAMPLE_DEPTH) ? longint'(SAMPLE_DEPTH) : end_reg;
  endfunction

  function automatic longint eff_start();
    longint e;
    e = eff_end();
    return (start_reg > e) ? e : start_reg;
  endfunction

  // sample at the play position scaled by both fade gains, truncated to zero
  function automatic longint faded_sample();
    longint s, e, p, a, b, lin, lout, smp;
    longint n1 = 1, d1 = 1, n2 = 1, d2 = 1;
    s = eff_start();
    e = eff_end();
    p = play_pos;
    if (!(s <= p && p < e) || p >= SAMPLE_DEPTH) return 0;
    if (rate_reg < 0) begin
      a = e - 1 - p; lin = fade_out_reg;
      b = p - s + 1; lout = fade_in_reg;
    end else begin
      a = p - s; lin = fade_in_reg;
      b = e - p; lout = fade_out_reg;
    end
    if (lin > 0 && a < lin) begin n1 = a; d1 = lin; end
    if (lout > 0 && b < lout) begin n2 = b; d2 = lout; end
    smp = sample_mem.exists(int'(p)) ? longint'(sample_mem[int'(p)]) : 0;
    return (smp * n1 * n2) / (d1 * d2);
  endfunction

  // phase accumulate, floor into the position, clamp to the playable range
  task automatic advance_voice(input logic signed [5:0] cnt);
    longint c, t, p, lo, hi;
    c = cnt;
    t = phase_frac + rate_reg * c;
    phase_frac = t & 64'hFFFF;
    p = play_pos + (t >>> 16);
    if (rate_reg < 0) begin lo = eff_start() - 1; hi = eff_end() - 1; end
    else begin lo = eff_start(); hi = eff_end(); end
    if (p < lo) p = lo;
    if (p > hi) p = hi;
    play_pos = p;
  endtask

  task automatic predict_voice(input logic [1:0] op, input logic [15:0] addr,
                               input logic signed [23:0] sval,
                               input logic signed [5:0] cnt);
    voice_result_t r;
    r.audio = '0;
    case (op)
      OP_WRITE: begin
        if (addr < SAMPLE_DEPTH) sample_mem[int'(addr)] = sval;
      end
      OP_RESTART: begin
        play_pos = (rate_reg < 0) ? eff_end() - 1 : eff_start();
        phase_frac = 0;
      end
      OP_STEP: begin
        r.audio = faded_sample();
        advance_voice(cnt);
      end
      default: ;
    endcase
    r.pos = play_pos[17:0];
    r.at_end = (rate_reg < 0) ? (play_pos == eff_start() - 1) : (play_pos == eff_end());
    voice_results_q.push_back(r);
    pending++;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // track config, predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    voice_result_t w;
    if (!rst_ni) begin
      play_pos = 0; phase_frac = 0;
      start_reg = 0; end_reg = 65536; fade_in_reg = 0; fade_out_reg = 0; rate_reg = 65536;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_START:    start_reg = cfg_wdata_i[16:0];
          CFG_END:      end_reg = cfg_wdata_i[16:0];
          CFG_FADE_IN:  fade_in_reg = cfg_wdata_i[16:0];
          CFG_FADE_OUT: fade_out_reg = cfg_wdata_i[16:0];
          CFG_RATE:     rate_reg = longint'($signed(cfg_wdata_i));
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        predict_voice(operation_i, address_i, sample_value_i, advance_count_i);
      if (out_valid_i && out_ready_i) begin
        if (pending == 0) begin
          report_mismatch("unexpected result, position", position_i, 0);
        end else begin
          w = voice_results_q.pop_front();
          pending--;
          if (audio_out_i !== w.audio) report_mismatch("audio_out", audio_out_i, w.audio);
          if (position_i !== w.pos) report_mismatch("position", position_i, w.pos);
          if (at_end_i !== w.at_end) report_mismatch("at_end", at_end_i, w.at_end);
        end
      end
    end
  end

endmodule

### verif/tb_top.sv
// tb_top: stimulus and verdict for variable_rate_sample_player_top
// depends on vsp_pkg, the player RTL and vsp_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vsp_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = OP_WRITE;
  logic [15:0]        address = '0;
  logic signed [23:0] sample_value = '0;
  logic signed [5:0]  advance_count = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [23:0] audio_out;
  logic signed [17:0] position;
  logic               at_end;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = CFG_START;
  logic [23:0]        cfg_wdata = '0;
  int                 err_count;

  bit                 sample_written[65536];
  int                 items_sent = 0;
  int                 results_seen = 0;
  logic signed [17:0] last_pos = '0;
  bit                 calm = 1'b0;
  int                 idle_cycles = 0;
  int                 cur_start = 0, cur_end = 65536, cur_fin = 0, cur_fout = 0, cur_rate = 65536;

  variable_rate_sample_player_top i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .address_i(address),
    .sample_value_i(sample_value), .advance_count_i(advance_count),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .audio_out_o(audio_out), .position_o(position), .at_end_o(at_end),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata)
  );

  vsp_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .operation_i(operation), .address_i(address),
    .sample_value_i(sample_value), .advance_count_i(advance_count),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .audio_out_i(audio_out), .position_i(position), .at_end_i(at_end),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .err_count_o(err_count)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // receiver stalls at random except in the calm stretch
  always @(posedge clk_i) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
  end

  // last position seen and result count
  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      last_pos <= position;
      results_seen <= results_seen + 1;
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                           input logic signed [23:0] val, input logic signed [5:0] cnt);
    if (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    operation <= op;
    address <= addr;
    sample_value <= val;
    advance_count <= cnt;
    do @(posedge clk_i); while (!in_ready);
    if (op == OP_WRITE) sample_written[addr] = 1'b1;
    items_sent++;
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    if (results_seen != items_sent) begin
      in_valid <= 1'b0;
      while (results_seen != items_sent) @(posedge clk_i);
    end
  endtask

  task automatic configure(input int s, input int e, input int fi, input int fo, input int r);
    drain();
    cur_start = s; cur_end = e; cur_fin = fi; cur_fout = fo; cur_rate = r;
    cfg_we <= 1'b1;
    cfg_index <= CFG_START;    cfg_wdata <= 24'(s);  @(posedge clk_i);
    cfg_index <= CFG_END;      cfg_wdata <= 24'(e);  @(posedge clk_i);
    cfg_index <= CFG_FADE_IN;  cfg_wdata <= 24'(fi); @(posedge clk_i);
    cfg_index <= CFG_FADE_OUT; cfg_wdata <= 24'(fo); @(posedge clk_i);
    cfg_index <= CFG_RATE;     cfg_wdata <= 24'(r);  @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // output and advance, writing the sample under the read position first if needed
  task automatic play_step(input logic signed [5:0] cnt);
    drain();
    if (last_pos >= 0 && last_pos <= 65535 && !sample_written[16'(last_pos)])
      send_item(OP_WRITE, 16'(last_pos), 24'($urandom), '0);
    send_item(OP_STEP, 16'($urandom), 24'($urandom), cnt);
  endtask

  function automatic int random_rate();
    case ($urandom_range(0, 7))
      0: return 8388607;
      1: return -8388608;
      2: return 0;
      3: return -int'($urandom_range(1, 3 << 16));
      4: return -int'($urandom_range(1, 1 << 14));
      5: return int'($urandom_range(1, 1 << 14));
      default: return int'($urandom_range(1, 3 << 16));
    endcase
  endfunction

  initial begin
    int base, nr;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every operation, empty and inverted ranges
    send_item(OP_WRITE, 16'd0, 24'sh7FFFFF, 6'sd0);
    send_item(OP_WRITE, 16'hFFFF, 24'sh800000, -6'sd16);
    send_item(OP_WRITE, 16'd1, 24'sh800000, 6'sd16);
    send_item(2'd3, 16'hFFFF, 24'sh7FFFFF, -6'sd1);
    send_item(OP_RESTART, 16'd0, 24'sd0, 6'sd0);
    play_step(6'sd1);
    play_step(6'sd0);
    play_step(6'sd16);
    play_step(-6'sd16);
    configure(0, 65536, 65536, 65536, -8388608);
    send_item(OP_RESTART, 16'd0, 24'sd0, 6'sd0);
    play_step(6'sd0);
    play_step(-6'sd16);
    play_step(6'sd16);
    configure(65536, 65536, 0, 0, 8388607);
    send_item(OP_RESTART, 16'd0, 24'sd0, 6'sd0);
    play_step(6'sd1);
    configure(5, 0, 3, 3, 0);
    send_item(OP_RESTART, 16'd0, 24'sd0, 6'sd0);
    play_step(6'sd7);
    configure(10, 20, 4, 4, 65536);
    send_item(OP_RESTART, 16'd0, 24'sd0, 6'sd0);
    repeat (4) play_step(6'sd3);

    // random phases, each with its own playback window
    for (int ph = 0; items_sent < 1450; ph++) begin
      calm = (ph == 4);
      base = $urandom_range(0, 65535);
      case (ph % 6)
        0: configure(0, 65536, 0, 0, random_rate());
        1: configure(base, 65536, $urandom_range(0, 65536), 65536, random_rate());
        default: configure(base, base + $urandom_range(0, 400) > 65536 ? 65536 :
                           base + $urandom_range(0, 400), $urandom_range(0, 300),
                           $urandom_range(0, 300), random_rate());
      endcase
      send_item(OP_RESTART, 16'($urandom), 24'($urandom), 6'($urandom));
      for (int k = 0; k < 160 && items_sent < 1450; k++) begin
        nr = $urandom_range(99);
        if (nr < 12)
          send_item(OP_RESTART, 16'($urandom), 24'($urandom), 6'($urandom));
        else if (nr < 22)
          send_item(OP_WRITE, (nr < 17) ? 16'(cur_start + $urandom_range(0, 400)) :
                    16'($urandom), 24'($urandom), 6'($urandom));
        else if (nr < 25)
          send_item(2'd3, 16'($urandom), 24'($urandom), 6'($urandom));
        else if (nr < 28)
          configure(cur_start, cur_end, cur_fin, cur_fout,
                    (cur_rate == -8388608) ? 8388607 : -cur_rate);
        else
          play_step(6'($urandom_range(0, 32) - 16));
      end
    end
    calm = 1'b0;

    drain();
    repeat (40) @(posedge clk_i);
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
